FILE: rtl/core/rmpt_pkg.sv
// Package for the multi-relay pulse timer: payload structs, codes and
// control types. No dependencies.
package rmpt_pkg;

    localparam int RMPT_RELAYS = 12;
    localparam int OUT_W       = 12;
    localparam int IDX_SPAN    = 16;
    localparam int TIME_W      = 16;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_TRIG   = 3'd1,
        OP_ON     = 3'd2,
        OP_OFF    = 3'd3,
        OP_QUERY  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_IDX  = 3'd1,
        ST_DISABLED = 3'd2,
        ST_ACTIVE   = 3'd3,
        ST_COOL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_COOL   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_ENABLE  = 3'd0,
        CFG_DEFAULT = 3'd1,
        CFG_COOL    = 3'd2,
        CFG_MIN     = 3'd3,
        CFG_MAX     = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_TICK = 2'd1,
        S_CMD  = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [3:0]        relay_index;
        logic [TIME_W-1:0] pulse_ms;
    } t_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [OUT_W-1:0]  relay_outputs;
        logic [1:0]        relay_mode;
        logic [TIME_W-1:0] remaining_ms;
    } t_res;

    typedef struct packed {
        logic tick_step;
        logic cmd_step;
        logic finish;
    } t_ctrl;

endpackage

FILE: rtl/core/rmpt_alu.sv
// Shared time unit: decrement with end-of-count flag and min/max clamp.
// Depends on rmpt_pkg.
module rmpt_alu
    import rmpt_pkg::*;
(
    input  logic [TIME_W-1:0] i_time,
    input  logic [TIME_W-1:0] i_len,
    input  logic [TIME_W-1:0] i_min,
    input  logic [TIME_W-1:0] i_max,
    output logic [TIME_W-1:0] o_dec,
    output logic              o_le1,
    output logic [TIME_W-1:0] o_clamped
);

    logic [TIME_W-1:0] lo_fix;

    assign o_dec     = i_time - TIME_W'(1);
    assign o_le1     = (i_time <= TIME_W'(1));
    assign lo_fix    = (i_len < i_min) ? i_min : i_len;
    assign o_clamped = (lo_fix > i_max) ? i_max : lo_fix;

endmodule

FILE: rtl/core/rmpt_ctrl.sv
// Sequencer: walks the relay bank once per tick, one relay a cycle, or
// runs a single command step. Depends on rmpt_pkg.
module rmpt_ctrl
    import rmpt_pkg::*;
#(
    parameter int RELAYS = RMPT_RELAYS,
    localparam int IW    = (RELAYS > 1) ? $clog2(RELAYS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_is_tick,
    output logic          o_busy,
    output logic [IW-1:0] o_cnt,
    output t_ctrl         o_ctl
);

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic          last;

    assign last = (r_cnt == IW'(RELAYS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = i_is_tick ? S_TICK : S_CMD;
                end
            end
            S_TICK: begin
                if (last) begin
                    n_state = S_DONE;
                end
            end
            S_CMD:   n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl  = '0;
        o_busy = 1'b1;
        n_cnt  = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                n_cnt  = '0;
            end
            S_TICK: begin
                o_ctl.tick_step = 1'b1;
                n_cnt           = r_cnt + IW'(1);
            end
            S_CMD:   o_ctl.cmd_step = 1'b1;
            S_DONE:  o_ctl.finish   = 1'b1;
            default: o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

FILE: rtl/core/multi_relay_pulse_timer_with_cooldown.sv
// Multi-relay pulse timer with cooldown: top level, configuration registers
// and relay state. Depends on rmpt_pkg, rmpt_alu and rmpt_ctrl.
// A tick steps one relay per cycle through the shared decrementer, then a
// done state registers the result; any other item runs one command step,
// then the done state. No new item is taken until busy falls; the receiver
// cannot stall. Sync active-low reset: relays idle, registers at defaults.
module multi_relay_pulse_timer_with_cooldown
    import rmpt_pkg::*;
#(
    parameter int RELAYS = RMPT_RELAYS,
    localparam int IW    = (RELAYS > 1) ? $clog2(RELAYS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    output logic               o_res_strobe,
    output t_res               o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [TIME_W-1:0]  i_cfg_data
);

    logic [OUT_W-1:0]  r_enable;
    logic [TIME_W-1:0] r_default, r_cool, r_min, r_max;

    t_mode             r_mode [RELAYS];
    logic [TIME_W-1:0] r_time [RELAYS];
    logic              r_hold [RELAYS];

    t_cmd              r_cmd;
    t_status           r_status, n_status;
    t_res              r_res;
    logic              r_res_vld;

    t_ctrl             ctl;
    logic [IW-1:0]     cnt;
    logic [IW-1:0]     addr;
    logic              accept;
    logic              bad_idx;
    logic              enabled;
    logic [IDX_SPAN-1:0] en_ext;

    t_mode             cur_mode;
    logic [TIME_W-1:0] cur_time;
    logic              cur_hold;

    logic              wr_en;
    t_mode             wr_mode;
    logic [TIME_W-1:0] wr_time;
    logic              wr_hold;

    logic [TIME_W-1:0] len_src, dec, clamped;
    logic              le1;
    logic [OUT_W-1:0]  drive;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= '0;
            r_default <= TIME_W'(1000);
            r_cool    <= '0;
            r_min     <= TIME_W'(100);
            r_max     <= TIME_W'(60000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE:  r_enable  <= i_cfg_data[OUT_W-1:0];
                CFG_DEFAULT: r_default <= i_cfg_data;
                CFG_COOL:    r_cool    <= i_cfg_data;
                CFG_MIN:     r_min     <= i_cfg_data;
                CFG_MAX:     r_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rmpt_ctrl #(.RELAYS(RELAYS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_is_tick (i_cmd.opcode == OP_TICK),
        .o_busy    (busy),
        .o_cnt     (cnt),
        .o_ctl     (ctl)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    assign addr     = ctl.tick_step ? cnt : r_cmd.relay_index[IW-1:0];
    assign cur_mode = r_mode[addr];
    assign cur_time = r_time[addr];
    assign cur_hold = r_hold[addr];
    assign bad_idx  = ({1'b0, r_cmd.relay_index} >= 5'(RELAYS));
    assign en_ext   = IDX_SPAN'(r_enable);
    assign enabled  = en_ext[r_cmd.relay_index];

    assign len_src = ctl.tick_step ? r_cool :
                     (r_cmd.pulse_ms != '0) ? r_cmd.pulse_ms : r_default;

    rmpt_alu u_alu (
        .i_time    (cur_time),
        .i_len     (len_src),
        .i_min     (r_min),
        .i_max     (r_max),
        .o_dec     (dec),
        .o_le1     (le1),
        .o_clamped (clamped)
    );

    always_comb begin
        wr_en    = 1'b0;
        wr_mode  = cur_mode;
        wr_time  = cur_time;
        wr_hold  = cur_hold;
        n_status = ST_OK;
        if (ctl.tick_step) begin
            if ((cur_mode == MODE_ACTIVE && !cur_hold) || cur_mode == MODE_COOL) begin
                wr_en = 1'b1;
                if (!le1) begin
                    wr_time = dec;
                end else if (cur_mode == MODE_ACTIVE && r_cool != '0) begin
                    wr_mode = MODE_COOL;
                    wr_time = clamped;
                end else begin
                    wr_mode = MODE_IDLE;
                    wr_time = '0;
                end
            end
        end else if (ctl.cmd_step) begin
            if (bad_idx) begin
                n_status = ST_BAD_IDX;
            end else begin
                case (r_cmd.opcode)
                    OP_TRIG: begin
                        if (!enabled) begin
                            n_status = ST_DISABLED;
                        end else if (cur_mode == MODE_ACTIVE) begin
                            n_status = ST_ACTIVE;
                        end else if (cur_mode == MODE_COOL) begin
                            n_status = ST_COOL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_mode = MODE_ACTIVE;
                            wr_hold = 1'b0;
                            wr_time = clamped;
                        end
                    end
                    OP_ON: begin
                        if (!enabled) begin
                            n_status = ST_DISABLED;
                        end else begin
                            wr_en   = 1'b1;
                            wr_mode = MODE_ACTIVE;
                            wr_hold = 1'b1;
                            wr_time = '0;
                        end
                    end
                    OP_OFF: begin
                        wr_en   = 1'b1;
                        wr_mode = MODE_IDLE;
                        wr_hold = 1'b0;
                        wr_time = '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RELAYS; i++) begin
                r_mode[i] <= MODE_IDLE;
                r_time[i] <= '0;
                r_hold[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_mode[addr] <= wr_mode;
            r_time[addr] <= wr_time;
            r_hold[addr] <= wr_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.cmd_step) begin
            r_status <= n_status;
        end else if (ctl.tick_step) begin
            r_status <= ST_OK;
        end
    end

    for (genvar g = 0; g < OUT_W; g++) begin : g_drive
        if (g < RELAYS) begin : g_on
            assign drive[g] = (r_mode[g] == MODE_ACTIVE);
        end else begin : g_off
            assign drive[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_res.status        <= r_status;
            r_res.relay_outputs <= drive;
            if (r_cmd.opcode == OP_TICK || bad_idx) begin
                r_res.relay_mode   <= MODE_IDLE;
                r_res.remaining_ms <= '0;
            end else begin
                r_res.relay_mode   <= cur_mode;
                r_res.remaining_ms <= (cur_mode == MODE_ACTIVE && !cur_hold) ? cur_time : '0;
            end
        end
    end

    assign o_res_strobe = r_res_vld;
    assign o_res        = r_res;

`ifndef SYNTH
    a_finish_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.finish |=> o_res_strobe)
        else $error("result strobe missing after finish");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_rem_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.remaining_ms != '0) |-> (o_res.relay_mode == MODE_ACTIVE))
        else $error("remaining time on a relay that is not active");
`endif

endmodule
